// ===== rtl/pldt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pldt_pkg
// Character classes, line status codes and the lexer transition table for the
// parameter line tokenizer.
// ----------------------------------------------------------------------------
package pldt_pkg;

    localparam int PLDT_MAX_LINE_COLUMNS = 256;
    localparam int PLDT_MAX_TOKENS       = 256;

    localparam int NUM_CLASSES = 10;

    // character classes
    localparam logic [3:0] CL_BLANK  = 4'd0;
    localparam logic [3:0] CL_WORD   = 4'd1;
    localparam logic [3:0] CL_ASSIGN = 4'd2;
    localparam logic [3:0] CL_SIGN   = 4'd3;
    localparam logic [3:0] CL_DIGIT  = 4'd4;
    localparam logic [3:0] CL_DOT    = 4'd5;
    localparam logic [3:0] CL_EXP    = 4'd6;
    localparam logic [3:0] CL_QUOTE  = 4'd7;
    localparam logic [3:0] CL_END    = 4'd8;
    localparam logic [3:0] CL_OTHER  = 4'd9;

    // line status
    localparam logic [1:0] ST_ACTIVE  = 2'd0;
    localparam logic [1:0] ST_COMMENT = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // next state numbered from 1, 0 = no transition
    localparam logic [4:0] NEXT_TAB [16][NUM_CLASSES] = '{
        '{ 5'd1, 5'd12, 5'd0,  5'd0, 5'd12, 5'd0,  5'd12, 5'd0, 5'd11, 5'd0},
        '{ 5'd0, 5'd2,  5'd0,  5'd0, 5'd2,  5'd2,  5'd2,  5'd3, 5'd0,  5'd0},
        '{ 5'd7, 5'd0,  5'd0,  5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd11, 5'd0},
        '{ 5'd7, 5'd0,  5'd0,  5'd0, 5'd4,  5'd0,  5'd10, 5'd0, 5'd11, 5'd0},
        '{ 5'd7, 5'd0,  5'd0,  5'd0, 5'd5,  5'd0,  5'd0,  5'd0, 5'd11, 5'd0},
        '{ 5'd0, 5'd0,  5'd0,  5'd0, 5'd5,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd7, 5'd0,  5'd0,  5'd9, 5'd8,  5'd0,  5'd0,  5'd2, 5'd11, 5'd0},
        '{ 5'd7, 5'd0,  5'd0,  5'd0, 5'd8,  5'd4,  5'd10, 5'd0, 5'd11, 5'd0},
        '{ 5'd0, 5'd0,  5'd0,  5'd0, 5'd8,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd0, 5'd0,  5'd0,  5'd6, 5'd5,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd0, 5'd0,  5'd0,  5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd15, 5'd12, 5'd14, 5'd0, 5'd12, 5'd13, 5'd12, 5'd0, 5'd0, 5'd0},
        '{ 5'd0, 5'd16, 5'd0,  5'd0, 5'd16, 5'd0,  5'd16, 5'd0, 5'd0,  5'd0},
        '{ 5'd14, 5'd0, 5'd0,  5'd9, 5'd8,  5'd0,  5'd0,  5'd2, 5'd0,  5'd0},
        '{ 5'd15, 5'd0, 5'd14, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd15, 5'd16, 5'd14, 5'd0, 5'd16, 5'd0, 5'd16, 5'd0, 5'd0,  5'd0}
    };

    // bit n set: state n stores characters
    localparam logic [15:0] STORES = 16'b1001_1011_1011_1110;

    function automatic logic [3:0] char_class(input logic [7:0] c);
        logic [3:0] cls;
        cls = CL_OTHER;
        if (c == 8'h20 || c == 8'h09) cls = CL_BLANK;
        else if (c == "-" || c == "+") cls = CL_SIGN;
        else if (c == "e" || c == "E" || c == "d" || c == "D") cls = CL_EXP;
        else if (c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) cls = CL_WORD;
        else if (c >= "0" && c <= "9") cls = CL_DIGIT;
        else if (c == ".") cls = CL_DOT;
        else if (c == 8'h22) cls = CL_QUOTE;
        else if (c == "=" || c == ":") cls = CL_ASSIGN;
        else if (c == "#") cls = CL_END;
        return cls;
    endfunction

    function automatic logic [4:0] next_lookup(input logic [3:0] st, input logic [3:0] cls);
        logic [4:0] nxt;
        nxt = 5'd0;
        if (cls < 4'(NUM_CLASSES)) nxt = NEXT_TAB[st][cls];
        return nxt;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/param_line_dfa_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// param_line_dfa_tokenizer
// Lexes one parameter-file line, one character per word.
//
// Slave side: one character per word on i_s_tdata, i_s_tlast high closes the
// line (its data byte is ignored). Master side: one result word per input
// word, o_m_tlast marks the line close result.
// A word moves through an input register, one table step, and a result
// register, whose valid bit drives o_m_tvalid.
// One word per cycle while the receiver is ready; the lexer state, status,
// token and column counters advance as each word leaves the input register.
// When the receiver stalls, the result register holds and the input register
// fills; o_s_tready drops once both are full and rises in the cycle the
// receiver takes a word.
// Reset (synchronous, active low) empties both registers and puts the lexer
// in its start state with an active line and zero counts.
// ----------------------------------------------------------------------------
module param_line_dfa_tokenizer #(
    parameter int MAX_LINE_COLUMNS = pldt_pkg::PLDT_MAX_LINE_COLUMNS,
    parameter int MAX_TOKENS       = pldt_pkg::PLDT_MAX_TOKENS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  wire logic        i_s_tlast,   // line_end
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [7:0] token_byte, [8] byte_kept, [9] token_done, [17:10] token_number,
    // [18] syntax_error, [26:19] error_column, [27] line_has_param, [31:28] 0
    output logic [31:0]      o_m_tdata,
    output logic             o_m_tlast    // line_done
);
    import pldt_pkg::*;

    localparam int CW = $clog2(MAX_LINE_COLUMNS + 1);
    localparam int TW = $clog2(MAX_TOKENS + 1);

    logic          r_in_vld;
    logic [7:0]    r_in_byte;
    logic          r_in_end;
    logic [3:0]    r_state,   n_state;
    logic [1:0]    r_status,  n_status;
    logic [TW-1:0] r_tok_cnt, n_tok_cnt;
    logic [CW-1:0] r_col_cnt, n_col_cnt;
    logic          r_out_vld;
    logic [31:0]   r_out_data, n_out_data;
    logic          r_out_last;

    logic          out_move;
    logic          step;
    logic [3:0]    cls;
    logic          active;
    logic [4:0]    lk;
    logic [3:0]    nxt;
    logic          err;
    logic          kept;
    logic          done;
    logic          has_param;
    logic [7:0]    tok_num;
    logic [7:0]    err_col;

    assign out_move   = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_in_vld || out_move;
    assign step       = r_in_vld && out_move;

    always_comb begin
        cls    = r_in_end ? CL_END : char_class(r_in_byte);
        active = (r_status == ST_ACTIVE);
        lk     = next_lookup(r_state, cls);
        nxt    = 4'(lk - 5'd1);
        err    = active && (lk == 5'd0);
        kept   = active && !err && STORES[nxt] && !r_in_end;
        done   = active && !err && !STORES[nxt] && STORES[r_state];

        tok_num = (32'(r_tok_cnt) > 32'd255) ? 8'hFF : 8'(r_tok_cnt);
        err_col = (32'(r_col_cnt) > 32'd255) ? 8'hFF : 8'(r_col_cnt);

        n_tok_cnt = r_tok_cnt;
        if (done && (32'(r_tok_cnt) < MAX_TOKENS)) n_tok_cnt = r_tok_cnt + TW'(1);

        n_status = r_status;
        if (err) begin
            n_status = ST_ERROR;
        end else if (active && cls == CL_END) begin
            n_status = ST_COMMENT;
        end

        has_param = r_in_end && (n_status != ST_ERROR) && (n_tok_cnt != '0);

        n_out_data        = '0;
        n_out_data[7:0]   = kept ? r_in_byte : 8'd0;
        n_out_data[8]     = kept;
        n_out_data[9]     = done;
        n_out_data[17:10] = tok_num;
        n_out_data[18]    = err;
        n_out_data[26:19] = err ? err_col : 8'd0;
        n_out_data[27]    = has_param;

        n_state   = (active && !err) ? nxt : r_state;
        n_col_cnt = r_col_cnt;
        if (32'(r_col_cnt) < MAX_LINE_COLUMNS) n_col_cnt = r_col_cnt + CW'(1);

        if (r_in_end) begin
            n_state   = 4'd0;
            n_status  = ST_ACTIVE;
            n_tok_cnt = '0;
            n_col_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= 4'd0;
            r_status  <= ST_ACTIVE;
            r_tok_cnt <= '0;
            r_col_cnt <= '0;
        end else begin
            if (o_s_tready) r_in_vld <= i_s_tvalid;
            if (out_move) r_out_vld <= r_in_vld;
            if (step) begin
                r_state   <= n_state;
                r_status  <= n_status;
                r_tok_cnt <= n_tok_cnt;
                r_col_cnt <= n_col_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
        if (step) begin
            r_out_data <= n_out_data;
            r_out_last <= r_in_end;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/pldt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pldt_checker
// Port-level checks for the parameter line tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module pldt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tlast
);

    // result word held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result word changed under stall");

    // kept byte, token end and error are exclusive
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot0(o_m_tdata[9:8]) &&
            !(o_m_tdata[18] && (o_m_tdata[8] || o_m_tdata[9])))
        else $error("kept/done/error overlap");

    // line close never keeps a byte
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> !o_m_tdata[8] && o_m_tdata[7:0] == 8'd0)
        else $error("byte kept on line close");

    // parameter flag only on an error-free line close
    a_param: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[27] |-> o_m_tlast && !o_m_tdata[18])
        else $error("line_has_param out of place");

    // reset empties the result register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind param_line_dfa_tokenizer pldt_checker u_pldt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

// ===== tb/param_line_dfa_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// param_line_dfa_tokenizer_tb
// Self-checking bench for the parameter line tokenizer. Lines are streamed in
// one character per word: a few hand-written lines first, then random lines,
// mostly well-formed name/value lines with random content, plus corrupted
// lines, lexical noise and raw bytes; two long hand-written lines come last. A
// scoreboard class runs its own lexer on every accepted word and compares
// each result word field by field. Both stream sides idle at random; one long
// receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module param_line_dfa_tokenizer_tb;

    import pldt_pkg::*;

    localparam int HOLD_CYCLES    = 240;
    localparam int QUIET_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_WORDS    = 200;

    // next lexer state numbered from 1, 0 = no transition
    localparam logic [4:0] LEX_NEXT [16][10] = '{
        '{ 5'd1,  5'd12, 5'd0,  5'd0, 5'd12, 5'd0,  5'd12, 5'd0, 5'd11, 5'd0},
        '{ 5'd0,  5'd2,  5'd0,  5'd0, 5'd2,  5'd2,  5'd2,  5'd3, 5'd0,  5'd0},
        '{ 5'd7,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd11, 5'd0},
        '{ 5'd7,  5'd0,  5'd0,  5'd0, 5'd4,  5'd0,  5'd10, 5'd0, 5'd11, 5'd0},
        '{ 5'd7,  5'd0,  5'd0,  5'd0, 5'd5,  5'd0,  5'd0,  5'd0, 5'd11, 5'd0},
        '{ 5'd0,  5'd0,  5'd0,  5'd0, 5'd5,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd7,  5'd0,  5'd0,  5'd9, 5'd8,  5'd0,  5'd0,  5'd2, 5'd11, 5'd0},
        '{ 5'd7,  5'd0,  5'd0,  5'd0, 5'd8,  5'd4,  5'd10, 5'd0, 5'd11, 5'd0},
        '{ 5'd0,  5'd0,  5'd0,  5'd0, 5'd8,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd0,  5'd0,  5'd0,  5'd6, 5'd5,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd0,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd15, 5'd12, 5'd14, 5'd0, 5'd12, 5'd13, 5'd12, 5'd0, 5'd0,  5'd0},
        '{ 5'd0,  5'd16, 5'd0,  5'd0, 5'd16, 5'd0,  5'd16, 5'd0, 5'd0,  5'd0},
        '{ 5'd14, 5'd0,  5'd0,  5'd9, 5'd8,  5'd0,  5'd0,  5'd2, 5'd0,  5'd0},
        '{ 5'd15, 5'd0,  5'd14, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0,  5'd0},
        '{ 5'd15, 5'd16, 5'd14, 5'd0, 5'd16, 5'd0,  5'd16, 5'd0, 5'd0,  5'd0}
    };

    // bit n set: lexer state n keeps characters
    localparam logic [15:0] LEX_KEEPS = 16'b1001_1011_1011_1110;

    typedef struct packed {
        logic [3:0] pad;
        logic       line_has_param;
        logic [7:0] error_column;
        logic       syntax_error;
        logic [7:0] token_number;
        logic       token_done;
        logic       byte_kept;
        logic [7:0] token_byte;
    } lex_result_t;

    function automatic logic [3:0] byte_class(input logic [7:0] c);
        if (c == 8'h20 || c == 8'h09) return CL_BLANK;
        if (c == "-" || c == "+") return CL_SIGN;
        if (c == "e" || c == "E" || c == "d" || c == "D") return CL_EXP;
        if (c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CL_WORD;
        if (c >= "0" && c <= "9") return CL_DIGIT;
        if (c == ".") return CL_DOT;
        if (c == 8'h22) return CL_QUOTE;
        if (c == "=" || c == ":") return CL_ASSIGN;
        if (c == "#") return CL_END;
        return CL_OTHER;
    endfunction

    function automatic logic [7:0] clip8(input int unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    class lexer_scoreboard;
        logic [3:0]   lex_state;
        logic [1:0]   line_status;
        int unsigned  tokens_done;
        int unsigned  columns;
        lex_result_t  cur;
        lex_result_t  want_q[$];
        logic         want_last_q[$];
        int unsigned  live_words;
        int unsigned  fail_count;

        function new();
            live_words = 0;
            fail_count = 0;
            restart_line();
        endfunction

        function void restart_line();
            lex_state   = 4'd0;
            line_status = ST_ACTIVE;
            tokens_done = 0;
            columns     = 0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void lex_step(input logic [3:0] cls, input logic [7:0] c);
            logic [4:0] nxt;
            logic [3:0] ns;
            nxt = LEX_NEXT[lex_state][cls];
            if (nxt == 5'd0) begin
                line_status       = ST_ERROR;
                cur.syntax_error  = 1'b1;
                cur.error_column  = clip8(columns);
                return;
            end
            ns = 4'(nxt - 5'd1);
            if (LEX_KEEPS[ns]) begin
                cur.token_byte = c;
                cur.byte_kept  = 1'b1;
            end else if (LEX_KEEPS[lex_state]) begin
                cur.token_done = 1'b1;
                if (tokens_done < PLDT_MAX_TOKENS) tokens_done++;
            end
            lex_state = ns;
            if (cls == CL_END) line_status = ST_COMMENT;
        endfunction

        function void note_input(input logic [7:0] c, input logic eol);
            live_words++;
            cur = '0;
            cur.token_number = clip8(tokens_done);
            if (eol) begin
                if (line_status == ST_ACTIVE) lex_step(CL_END, 8'h00);
                cur.token_byte     = 8'h00;
                cur.byte_kept      = 1'b0;
                cur.line_has_param = (line_status != ST_ERROR) && (tokens_done > 0);
                restart_line();
            end else begin
                if (line_status == ST_ACTIVE) lex_step(byte_class(c), c);
                if (columns < PLDT_MAX_LINE_COLUMNS) columns++;
            end
            want_q      = {want_q, cur};
            want_last_q = {want_last_q, eol};
        endfunction

        function string show(input lex_result_t r, input logic last);
            return $sformatf("byte=%h kept=%b done=%b num=%0d err=%b col=%0d param=%b last=%b pad=%h",
                             r.token_byte, r.byte_kept, r.token_done, r.token_number,
                             r.syntax_error, r.error_column, r.line_has_param, last, r.pad);
        endfunction

        function void check_result(input logic [31:0] data, input logic last);
            lex_result_t got;
            lex_result_t want;
            logic        want_last;
            bit          bad;
            got = data;
            if (want_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: result word with nothing expected: %s", show(got, last));
                return;
            end
            want      = want_q.pop_front();
            want_last = want_last_q.pop_front();
            bad = (got.token_byte     !== want.token_byte)     ||
                  (got.byte_kept      !== want.byte_kept)      ||
                  (got.token_done     !== want.token_done)     ||
                  (got.token_number   !== want.token_number)   ||
                  (got.syntax_error   !== want.syntax_error)   ||
                  (got.error_column   !== want.error_column)   ||
                  (got.line_has_param !== want.line_has_param) ||
                  (got.pad            !== 4'h0)                ||
                  (last               !== want_last);
            if (bad) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("ERROR: result mismatch at %0t", $time);
                    $display("  expected %s", show(want, want_last));
                    $display("  actual   %s", show(got, last));
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;     // [7:0] char_byte
    logic        i_s_tlast;     // line_end
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;     // [7:0] token_byte, [8] byte_kept, [9] token_done,
                                // [17:10] token_number, [18] syntax_error,
                                // [26:19] error_column, [27] line_has_param
    logic        o_m_tlast;     // line_done

    lexer_scoreboard sb;
    logic [7:0]      line_buf[$];
    int              src_idle_pct;
    int              dst_idle_pct;
    bit              hold_req;

    param_line_dfa_tokenizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random ready, or a long counted hold-off on request
    initial begin : sink
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    initial begin : monitor
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (i_s_tvalid && o_s_tready) sb.note_input(i_s_tdata, i_s_tlast);
                if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tlast);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic void put_char(input logic [7:0] c);
        line_buf = {line_buf, c};
    endfunction

    task automatic send_word(input logic [7:0] c, input logic eol);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= eol;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_eol();
        send_word(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++) send_word(line_buf[i], 1'b0);
        send_eol();
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic add_blanks(input int lo, input int hi);
        repeat ($urandom_range(hi, lo)) put_char(pick(" \t"));
    endtask

    task automatic add_number();
        if ($urandom_range(2) == 0) put_char(pick("+-"));
        repeat ($urandom_range(4, 1)) put_char(pick("0123456789"));
        if ($urandom_range(2) == 0) begin
            put_char(".");
            repeat ($urandom_range(3)) put_char(pick("0123456789"));
        end
        if ($urandom_range(2) == 0) begin
            put_char(pick("eEdD"));
            if ($urandom_range(1)) put_char(pick("+-"));
            repeat ($urandom_range(3, 1)) put_char(pick("0123456789"));
        end
    endtask

    task automatic add_string();
        put_char(8'h22);
        repeat ($urandom_range(5)) put_char(pick("abzAZ_09.eD"));
        put_char(8'h22);
    endtask

    // name, assign mark, values, optional comment
    task automatic build_param_line();
        int n_vals;
        int k;
        line_buf.delete();
        add_blanks(0, 2);
        put_char(pick("abcdezABCDEZ_09"));
        repeat ($urandom_range(6)) put_char(pick("aqzAQZ_059eEdD"));
        if ($urandom_range(3) == 0) begin
            put_char(".");
            repeat ($urandom_range(3, 1)) put_char(pick("aqzAQZ_059eEdD"));
        end
        add_blanks(0, 2);
        put_char($urandom_range(1) ? "=" : ":");
        n_vals = $urandom_range(5, 1);
        for (k = 0; k < n_vals; k++) begin
            add_blanks((k == 0) ? 0 : 1, 2);
            if ($urandom_range(3) == 0) add_string();
            else add_number();
        end
        add_blanks(0, 2);
        if ($urandom_range(2) == 0) begin
            put_char("#");
            repeat ($urandom_range(4)) put_char(8'($urandom_range(255)));
        end
    endtask

    task automatic corrupt_line();
        int pos;
        if (line_buf.size() == 0 || $urandom_range(3) != 0) return;
        pos = $urandom_range(line_buf.size() - 1);
        case ($urandom_range(2))
            0: line_buf[pos] = 8'($urandom_range(255));
            1: line_buf[pos] = pick(" \taeEdD_Z09.+-=:#!");
            default: begin
                while (line_buf.size() > pos) void'(line_buf.pop_back());
            end
        endcase
    endtask

    task automatic random_line();
        int pct;
        pct = $urandom_range(99);
        line_buf.delete();
        if (pct < 65) begin
            build_param_line();
            corrupt_line();
        end else if (pct < 78) begin
            repeat ($urandom_range(16, 1)) put_char(pick(" \taeEdD_Z09.+-=:#!\""));
        end else if (pct < 88) begin
            repeat ($urandom_range(20)) put_char(8'($urandom_range(255)));
        end else begin
            add_blanks(0, 3);
            if ($urandom_range(1)) begin
                put_char("#");
                repeat ($urandom_range(5)) put_char(8'($urandom_range(255)));
            end
        end
        send_line();
    endtask

    task automatic run_phase(input int src_pct, input int dst_pct, input bit with_hold);
        int unsigned start;
        bit          held;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        start        = sb.live_words;
        held         = 1'b0;
        while (sb.live_words - start < PHASE_WORDS) begin
            if (with_hold && !held && sb.live_words - start > PHASE_WORDS / 2) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            random_line();
        end
        drain();
    endtask

    initial begin : stimulus
        int i;
        sb           = new();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_req     = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        i_s_tlast  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full value line with string and comment, then ignored byte
        send_text("x=-1.5E+2 \"s1\" #");
        send_word(8'hFF, 1'b0);
        send_eol();
        // empty line
        send_eol();
        // bad character, rest ignored
        send_text("a=&");
        send_word(8'h00, 1'b0);
        send_eol();
        // line ends right after the assign mark
        send_text("b:");
        send_eol();
        drain();

        run_phase(34, 70, 1'b0);
        run_phase(70, 34, 1'b0);
        run_phase(0, 0, 1'b1);

        // token count saturation
        line_buf.delete();
        put_char("n");
        put_char("=");
        for (i = 0; i < 260; i++) begin
            put_char("7");
            put_char(" ");
        end
        send_line();
        // error past the saturating column
        line_buf.delete();
        put_char("L");
        put_char("=");
        for (i = 0; i < 110; i++) begin
            put_char("1");
            put_char("2");
            put_char(" ");
        end
        put_char("!");
        put_char("x");
        send_line();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
